### hdl/rcl_pkg.sv
// Shared types, status codes and command/status bundles for the link cache.
package rcl_pkg;

  localparam int DEFAULT_CAPACITY = 64;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int REFS_W   = 16;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;

  // Transaction kinds
  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICTED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REL_ERROR = 3'd5;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic                proof;
    logic                identity;
    logic [HANDLE_W-1:0] handle;
    logic [REFS_W-1:0]   refs;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture the incoming transaction, reset scan
    logic rel_read;   // read the entry named by release_slot
    logic scan;       // issue next scan read
    logic hit_done;   // finish acquire on hit
    logic miss_done;  // finish acquire on miss
    logic rel_done;   // finish release
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hit;
    logic drained;
  } dp_stat_t;

endpackage

### hdl/rcl_ctrl.sv
// Sequencing state machine for the link cache.
module rcl_ctrl
  import rcl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_kind,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_RELEASE) begin
            cmd.rel_read = 1'b1;
            state_nxt    = S_REL;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.hit) begin
          cmd.hit_done = 1'b1;
          state_nxt    = S_IDLE;
        end else if (stat.drained) begin
          cmd.miss_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_REL: begin
        cmd.rel_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

### hdl/rcl_datapath.sv
// Entry memory, fill count, scan pipeline and result registers of the link cache.
module rcl_datapath
  import rcl_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic signed [KEY_W-1:0]    in_src_hash,
  input  logic signed [KEY_W-1:0]    in_des_hash,
  input  logic signed [KEY_W-1:0]    in_rend_hash,
  input  logic                       in_softproof,
  input  logic        [HANDLE_W-1:0] in_new_handle,
  input  logic        [SLOT_W-1:0]   in_release_slot,
  output logic                       out_valid,
  output logic        [STATUS_W-1:0] out_status,
  output logic        [SLOT_W-1:0]   out_slot,
  output logic        [HANDLE_W-1:0] out_handle,
  output logic                       out_ident,
  output logic        [REFS_W-1:0]   out_refs
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

  // Entry memory: valid slots are always 0 .. vc_r-1 (filled in order, never freed)
  entry_t mem [CAPACITY];

  // Captured transaction
  logic [KEY_W-1:0]    key_r;
  logic                proof_r;
  logic                ident_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [SLOT_W-1:0]   rslot_r;

  logic [CW-1:0] vc_r, vc_nxt;
  logic [CW-1:0] req_r, req_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;
  logic          zfound_r, zfound_nxt;
  logic [AW-1:0] zidx_r, zidx_nxt;
  entry_t        rd_data_r;

  logic          issue;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rel_ok;

  logic                out_valid_nxt;
  logic [STATUS_W-1:0] out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_nxt;
  logic [HANDLE_W-1:0] out_handle_nxt;
  logic                out_ident_nxt;
  logic [REFS_W-1:0]   out_refs_nxt;

  assign issue = cmd.scan && (req_r < vc_r);
  assign rd_addr = cmd.rel_read ? AW'(in_release_slot) : req_r[AW-1:0];

  assign stat.hit = chk_vld_r && (rd_data_r.key == key_r) && (rd_data_r.proof == proof_r);
  assign stat.drained = !chk_vld_r && !(req_r < vc_r);

  assign rel_ok = CMPW'(rslot_r) < CMPW'(vc_r);

  always_comb begin
    req_nxt        = req_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = req_r[AW-1:0];
    zfound_nxt     = zfound_r;
    zidx_nxt       = zidx_r;
    vc_nxt         = vc_r;
    we             = 1'b0;
    wr_addr        = chk_idx_r;
    wr_data        = rd_data_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_HIT;
    out_slot_nxt   = '0;
    out_handle_nxt = '0;
    out_ident_nxt  = 1'b0;
    out_refs_nxt   = '0;

    if (cmd.load) begin
      req_nxt    = '0;
      zfound_nxt = 1'b0;
    end

    if (issue) begin
      req_nxt     = req_r + CW'(1);
      chk_vld_nxt = 1'b1;
    end

    // lowest-numbered entry with no references, candidate for eviction;
    // only while scanning, a read left over from a hit must not count
    if (cmd.scan && chk_vld_r && (rd_data_r.refs == '0) && !zfound_r) begin
      zfound_nxt = 1'b1;
      zidx_nxt   = chk_idx_r;
    end

    if (cmd.hit_done) begin
      we            = 1'b1;
      wr_addr       = chk_idx_r;
      if (rd_data_r.refs != REFS_MAX)
        wr_data.refs = rd_data_r.refs + REFS_W'(1);
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_HIT;
      out_slot_nxt   = SLOT_W'(chk_idx_r);
      out_handle_nxt = rd_data_r.handle;
      out_ident_nxt  = rd_data_r.identity;
      out_refs_nxt   = wr_data.refs;
    end

    if (cmd.miss_done) begin
      out_valid_nxt    = 1'b1;
      wr_data.key      = key_r;
      wr_data.proof    = proof_r;
      wr_data.identity = ident_r;
      wr_data.handle   = handle_r;
      wr_data.refs     = REFS_W'(1);
      priority if (vc_r < CW'(CAPACITY)) begin
        we             = 1'b1;
        wr_addr        = vc_r[AW-1:0];
        vc_nxt         = vc_r + CW'(1);
        out_status_nxt = ST_INSERTED;
      end else if (zfound_r) begin
        we             = 1'b1;
        wr_addr        = zidx_r;
        out_status_nxt = ST_EVICTED;
      end else begin
        out_status_nxt = ST_FULL;
      end
      if (we) begin
        out_slot_nxt   = SLOT_W'(wr_addr);
        out_handle_nxt = handle_r;
        out_ident_nxt  = ident_r;
        out_refs_nxt   = REFS_W'(1);
      end
    end

    if (cmd.rel_done) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = rslot_r;
      wr_addr       = AW'(rslot_r);
      priority if (!rel_ok) begin
        out_status_nxt = ST_REL_ERROR;
      end else if (rd_data_r.refs == '0) begin
        out_status_nxt = ST_REL_ERROR;
        out_handle_nxt = rd_data_r.handle;
        out_ident_nxt  = rd_data_r.identity;
      end else begin
        we             = 1'b1;
        wr_data.refs   = rd_data_r.refs - REFS_W'(1);
        out_status_nxt = ST_RELEASED;
        out_handle_nxt = rd_data_r.handle;
        out_ident_nxt  = rd_data_r.identity;
        out_refs_nxt   = wr_data.refs;
      end
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Transaction capture and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_src_hash ^ in_des_hash ^ in_rend_hash;
      proof_r  <= in_softproof;
      ident_r  <= (in_src_hash == in_des_hash);
      handle_r <= in_new_handle;
      rslot_r  <= in_release_slot;
    end
    chk_idx_r       <= chk_idx_nxt;
    zidx_r          <= zidx_nxt;
    req_r           <= req_nxt;
    if (out_valid_nxt) begin
      out_status <= out_status_nxt;
      out_slot   <= out_slot_nxt;
      out_handle <= out_handle_nxt;
      out_ident  <= out_ident_nxt;
      out_refs   <= out_refs_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r      <= '0;
      chk_vld_r <= 1'b0;
      zfound_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vc_r      <= vc_nxt;
      chk_vld_r <= chk_vld_nxt;
      zfound_r  <= zfound_nxt;
      out_valid <= out_valid_nxt;
    end
  end

endmodule

### hdl/refcounted_link_cache.sv
// Results: for a release, out_valid is registered after the read of the named entry; for an
//   acquire it follows a hit in slot h, or on a miss the scan of all N filled slots (or,
//   on an empty table, no scan at all), with the memory scan reading one entry per cycle.
// Throughput: one transaction at a time; start is taken whenever busy is low, which
//   includes the cycle in which the previous result is on the out_ ports.
// Results are never stalled: out_valid is high for one cycle; reset clears the fill count.
module refcounted_link_cache
  import rcl_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request side
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic signed [KEY_W-1:0]    in_src_hash,
  input  logic signed [KEY_W-1:0]    in_des_hash,
  input  logic signed [KEY_W-1:0]    in_rend_hash,
  input  logic                       in_softproof,
  input  logic        [HANDLE_W-1:0] in_new_handle,
  input  logic        [SLOT_W-1:0]   in_release_slot,
  // result side
  output logic                       out_valid,
  output logic        [STATUS_W-1:0] out_status,
  output logic        [SLOT_W-1:0]   out_slot,
  output logic        [HANDLE_W-1:0] out_handle,
  output logic                       out_ident,
  output logic        [REFS_W-1:0]   out_refs
);

  // Controller decides when to scan, hit, insert/evict or release;
  // datapath owns the entry memory and all arithmetic.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The FSM only advances from IDLE when busy is low, so start alone
  // is a valid accept qualifier inside the controller.
  rcl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Filled slots are always contiguous from slot 0, so a fill count
  // stands in for per-entry valid bits; eviction reuses a slot in place.
  rcl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_src_hash     (in_src_hash),
    .in_des_hash     (in_des_hash),
    .in_rend_hash    (in_rend_hash),
    .in_softproof    (in_softproof),
    .in_new_handle   (in_new_handle),
    .in_release_slot (in_release_slot),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_handle      (out_handle),
    .out_ident       (out_ident),
    .out_refs        (out_refs)
  );

endmodule
